FILE: rtl/wdp_pkg.sv
// ----------------------------------------------------------------------------
// wdp_pkg
// Shared types and constants of the windowed dot-plot cell engine.
// ----------------------------------------------------------------------------
`default_nettype none

package wdp_pkg;

  localparam int CMD_W      = 2;
  localparam int POS_W      = 7;
  localparam int SYM_W      = 8;
  localparam int CNT_W      = 5;
  localparam int THR_W      = 5;
  localparam int LEN_W      = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(100);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_EVAL        = 2'd2,
    CMD_NONE        = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_ACTIVE_LEN = 2'd1
  } reg_idx_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [SYM_W-1:0] sym;
    logic             fit;
    logic             in_range;
  } s1_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             fit;
  } cell_t;

endpackage

`default_nettype wire

FILE: rtl/windowed_dot_plot_cell_top.sv
// ----------------------------------------------------------------------------
// windowed_dot_plot_cell_top
// Dot-plot cell engine over two banked symbol stores, four pipeline stages.
//
// Channel  Direction  Handshake                 Contents
// in_      slave      in_tvalid / in_tready     tuser: command; tdata: position, symbol
// out_     master     out_tvalid / out_tready   tdata: cell, match count, dot
// cfg_     slave      cfg_valid / cfg_ready     register index and write data
//
// One item is taken per clock cycle unless a stalled output has filled the
// stages ahead of it. Each store is split into banks by the low index
// bits so that every window position sits in its own bank, one read per bank a
// cycle. Reset is synchronous and active low and empties the pipeline.
// A stalled output holds every stage that is full; no item is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_dot_plot_cell_top #(
  parameter int MAX_LENGTH  = 128,
  parameter int HALF_WINDOW = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [1:0] command
  input  wire logic [wdp_pkg::CMD_W-1:0]      in_tuser,
  // [6:0] pos_x, [13:7] pos_y, [21:14] symbol, [23:22] zero
  input  wire logic [wdp_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [6:0] cell_x, [13:7] cell_y, [18:14] match_count, [19] dot, [23:20] zero
  output logic      [wdp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [wdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wdp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wdp_pkg::*;

  localparam int W      = 2 * HALF_WINDOW + 1;
  localparam int LB     = $clog2(W);
  localparam int NB     = 1 << LB;
  localparam int AW     = $clog2(MAX_LENGTH);
  localparam int IW     = (AW > POS_W ? AW : POS_W) + 1;
  localparam int DEPB   = (MAX_LENGTH + NB - 1) / NB;
  localparam int RW     = DEPB > 1 ? $clog2(DEPB) : 1;
  localparam int LenCap = MAX_LENGTH < 255 ? MAX_LENGTH : 255;

  logic [THR_W-1:0] thr_r;
  logic [LEN_W-1:0] alen_r;
  logic [LEN_W-1:0] eff_len;

  logic             in_fire;
  logic             en1, en2, en3;

  logic             v1;
  s1_t              s1;
  logic [RW-1:0]    xrow1 [NB];
  logic [RW-1:0]    yrow1 [NB];
  logic [LB-1:0]    xlo1, ylo1;

  logic             v2_r;
  cell_t            tag2_r;
  logic [LB-1:0]    xlo2_r, ylo2_r;
  logic [SYM_W-1:0] rd_first  [NB];
  logic [SYM_W-1:0] rd_second [NB];

  logic [IW-1:0]    xw1;
  logic             wr_first, wr_second;

  cell_t            tag4;
  logic [CNT_W-1:0] cnt4;
  logic             dot4;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      alen_r <= LEN_RESET;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD:  thr_r  <= cfg_data[THR_W-1:0];
        REG_ACTIVE_LEN: alen_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_len = (alen_r > LEN_W'(LenCap)) ? LEN_W'(LenCap) : alen_r;

  assign en2       = !v2_r || en3;
  assign en1       = !v1 || en2;
  assign in_tready = en1;
  assign in_fire   = in_tvalid && in_tready;

  wdp_front #(
    .MAX_LENGTH (MAX_LENGTH),
    .HALF_WINDOW(HALF_WINDOW),
    .NB         (NB),
    .LB         (LB),
    .RW         (RW),
    .IW         (IW)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en1),
    .in_fire(in_fire),
    .cmd    (cmd_t'(in_tuser)),
    .x      (in_tdata[6:0]),
    .y      (in_tdata[13:7]),
    .sym    (in_tdata[21:14]),
    .eff_len(eff_len),
    .v_r    (v1),
    .s1_r   (s1),
    .xrow_r (xrow1),
    .yrow_r (yrow1),
    .xlo_r  (xlo1),
    .ylo_r  (ylo1)
  );

  assign xw1       = IW'(s1.x);
  assign wr_first  = v1 && en2 && s1.in_range && (s1.cmd == CMD_LOAD_FIRST);
  assign wr_second = v1 && en2 && s1.in_range && (s1.cmd == CMD_LOAD_SECOND);

  for (genvar b = 0; b < NB; b++) begin : g_bank
    wdp_bank_mem #(.RW(RW)) u_first (
      .clk    (clk),
      .we     (wr_first && (xw1[LB-1:0] == LB'(b))),
      .waddr  (xw1[LB +: RW]),
      .wdata  (s1.sym),
      .re     (en2),
      .raddr  (xrow1[b]),
      .rdata_r(rd_first[b])
    );
    wdp_bank_mem #(.RW(RW)) u_second (
      .clk    (clk),
      .we     (wr_second && (xw1[LB-1:0] == LB'(b))),
      .waddr  (xw1[LB +: RW]),
      .wdata  (s1.sym),
      .re     (en2),
      .raddr  (yrow1[b]),
      .rdata_r(rd_second[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1 && (s1.cmd == CMD_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      tag2_r <= '{x: s1.x, y: s1.y, fit: s1.fit};
      xlo2_r <= xlo1;
      ylo2_r <= ylo1;
    end
  end

  wdp_score #(
    .HALF_WINDOW(HALF_WINDOW),
    .NB         (NB),
    .LB         (LB)
  ) u_score (
    .clk      (clk),
    .rst_n    (rst_n),
    .v_in     (v2_r),
    .tag_in   (tag2_r),
    .xlo      (xlo2_r),
    .ylo      (ylo2_r),
    .rd_first (rd_first),
    .rd_second(rd_second),
    .thr      (thr_r),
    .out_ready(out_tready),
    .en_in    (en3),
    .v_out_r  (out_tvalid),
    .tag_out_r(tag4),
    .cnt_out_r(cnt4),
    .dot_out_r(dot4)
  );

  assign out_tdata = {4'b0000, dot4, cnt4, tag4.y, tag4.x};

endmodule

`default_nettype wire

FILE: rtl/wdp_bank_mem.sv
// ----------------------------------------------------------------------------
// wdp_bank_mem
// One symbol bank: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module wdp_bank_mem #(
  parameter int RW = 3
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [RW-1:0]             waddr,
  input  wire logic [wdp_pkg::SYM_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [RW-1:0]             raddr,
  output logic      [wdp_pkg::SYM_W-1:0] rdata_r
);
  import wdp_pkg::*;

  logic [SYM_W-1:0] mem [1 << RW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wdp_front.sv
// ----------------------------------------------------------------------------
// wdp_front
// First stage: decodes an item, checks the window against the active length
// and forms the row address of every bank for both sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module wdp_front #(
  parameter int MAX_LENGTH  = 128,
  parameter int HALF_WINDOW = 5,
  parameter int NB          = 16,
  parameter int LB          = 4,
  parameter int RW          = 3,
  parameter int IW          = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_fire,
  input  wire wdp_pkg::cmd_t             cmd,
  input  wire logic [wdp_pkg::POS_W-1:0] x,
  input  wire logic [wdp_pkg::POS_W-1:0] y,
  input  wire logic [wdp_pkg::SYM_W-1:0] sym,
  input  wire logic [wdp_pkg::LEN_W-1:0] eff_len,
  output logic                           v_r,
  output wdp_pkg::s1_t                   s1_r,
  output logic      [RW-1:0]             xrow_r [NB],
  output logic      [RW-1:0]             yrow_r [NB],
  output logic      [LB-1:0]             xlo_r,
  output logic      [LB-1:0]             ylo_r
);
  import wdp_pkg::*;

  logic [IW-1:0] xw, yw, xs, ys, ix, iy;
  logic [LB-1:0] offx, offy;
  logic [RW-1:0] xrow_nxt [NB];
  logic [RW-1:0] yrow_nxt [NB];
  logic          fit_nxt;
  logic          in_range_nxt;

  always_comb begin
    xw = IW'(x);
    yw = IW'(y);
    xs = xw - IW'(HALF_WINDOW);
    ys = yw - IW'(HALF_WINDOW);
    ix = '0;
    iy = '0;
    offx = '0;
    offy = '0;
    for (int b = 0; b < NB; b++) begin
      offx = LB'(b) - xs[LB-1:0];
      offy = LB'(b) - ys[LB-1:0];
      ix = xs + IW'(offx);
      iy = ys + IW'(offy);
      xrow_nxt[b] = ix[LB +: RW];
      yrow_nxt[b] = iy[LB +: RW];
    end
    fit_nxt = (9'(x) >= 9'(HALF_WINDOW)) && (9'(x) + 9'(HALF_WINDOW) < 9'(eff_len)) &&
              (9'(y) >= 9'(HALF_WINDOW)) && (9'(y) + 9'(HALF_WINDOW) < 9'(eff_len));
    in_range_nxt = int'(x) < MAX_LENGTH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_fire) begin
      s1_r     <= '{cmd: cmd, x: x, y: y, sym: sym, fit: fit_nxt, in_range: in_range_nxt};
      xrow_r   <= xrow_nxt;
      yrow_r   <= yrow_nxt;
      xlo_r    <= xs[LB-1:0];
      ylo_r    <= ys[LB-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wdp_score.sv
// ----------------------------------------------------------------------------
// wdp_score
// Last two stages: lines the bank outputs up in window order and compares
// them, then counts the equal pairs and applies the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module wdp_score #(
  parameter int HALF_WINDOW = 5,
  parameter int NB          = 16,
  parameter int LB          = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      v_in,
  input  wire wdp_pkg::cell_t            tag_in,
  input  wire logic [LB-1:0]             xlo,
  input  wire logic [LB-1:0]             ylo,
  input  wire logic [wdp_pkg::SYM_W-1:0] rd_first  [NB],
  input  wire logic [wdp_pkg::SYM_W-1:0] rd_second [NB],
  input  wire logic [wdp_pkg::THR_W-1:0] thr,
  input  wire logic                      out_ready,
  output logic                           en_in,
  output logic                           v_out_r,
  output wdp_pkg::cell_t                 tag_out_r,
  output logic      [wdp_pkg::CNT_W-1:0] cnt_out_r,
  output logic                           dot_out_r
);
  import wdp_pkg::*;

  localparam int W = 2 * HALF_WINDOW + 1;

  logic             v3_r;
  cell_t            tag3_r;
  logic [W-1:0]     eq3_r;
  logic [W-1:0]     eq_nxt;
  logic [LB-1:0]    ia, ib;
  logic [CNT_W-1:0] cnt_nxt;
  logic             dot_nxt;
  logic             en4;

  assign en4   = !v_out_r || out_ready;
  assign en_in = !v3_r || en4;

  always_comb begin
    ia = '0;
    ib = '0;
    for (int k = 0; k < W; k++) begin
      ia = xlo + LB'(k);
      ib = ylo + LB'(k);
      eq_nxt[k] = (rd_first[ia] == rd_second[ib]);
    end
  end

  always_comb begin
    cnt_nxt = '0;
    for (int k = 0; k < W; k++) begin
      cnt_nxt = cnt_nxt + CNT_W'(eq3_r[k]);
    end
    if (!tag3_r.fit) begin
      cnt_nxt = '0;
    end
    dot_nxt = tag3_r.fit && (cnt_nxt >= thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      v_out_r <= 1'b0;
    end else begin
      if (en_in) begin
        v3_r <= v_in;
      end
      if (en4) begin
        v_out_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_in) begin
      tag3_r <= tag_in;
      eq3_r  <= eq_nxt;
    end
    if (en4) begin
      tag_out_r <= tag3_r;
      cnt_out_r <= cnt_nxt;
      dot_out_r <= dot_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wdp_checker.sv
// ----------------------------------------------------------------------------
// wdp_checker
// Port-level checks of the dot-plot cell engine, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wdp_checker #(
  parameter int HALF_WINDOW = 5
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [wdp_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int W = 2 * HALF_WINDOW + 1;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while the output is free");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:20] == 4'b0000) && (int'(out_tdata[18:14]) <= W))
    else $error("result count out of range or padding set");

endmodule

bind windowed_dot_plot_cell_top wdp_checker #(.HALF_WINDOW(HALF_WINDOW)) u_wdp_checker (.*);

`default_nettype wire
